FILE: src/stm_pkg.sv
// stm_pkg: shared types and codes for the three-mode software timer
// depends on nothing; imported by soft_timer_three_mode and its bench
package stm_pkg;

   localparam int unsigned TIME_WIDTH_DEFAULT = 32;
   localparam int unsigned NOW_WIDTH          = 32;
   localparam int unsigned PERIOD_WIDTH       = 32;
   localparam int unsigned CSR_DATA_WIDTH     = 32;
   localparam int unsigned CSR_INDEX_WIDTH    = 1;

   typedef enum logic [1:0] {
      ST_STOPPED = 2'd0,
      ST_RUNNING = 2'd1,
      ST_ELAPSED = 2'd2
   } state_type;

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0,
      OP_START = 2'd1,
      OP_STOP  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_ONESHOT  = 2'd0,
      MODE_PERIODIC = 2'd1,
      MODE_HARD     = 2'd2
   } mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TIMER_MODE = 1'd0,
      CSR_PERIOD_MS  = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]           opcode;
      logic [NOW_WIDTH-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       occurred;
      logic [1:0] timer_state;
   } rsp_type;

endpackage

FILE: src/soft_timer_three_mode.sv
// soft_timer_three_mode: a word moves from input register to result register
// throughput one word per cycle when not stalled; the run state is updated as each
// word leaves the input register, so the next word sees it in the following cycle
// reset (synchronous, active high) clears both stages, the run state (stopped),
// the start time and both registers (one-shot mode, zero period)
// depends on stm_pkg
module soft_timer_three_mode
   import stm_pkg::*;
#(
   parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   localparam int unsigned BASE_WIDTH = (TIME_WIDTH > NOW_WIDTH) ? TIME_WIDTH : NOW_WIDTH;
   localparam int unsigned CMP_WIDTH  = BASE_WIDTH + 2;

   logic                    req_valid_ff;
   req_type                 req_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;
   state_type               state_ff;
   state_type               state_in;
   logic [TIME_WIDTH-1:0]   start_ff;
   logic [TIME_WIDTH-1:0]   start_in;
   logic [1:0]              mode_ff;
   logic [PERIOD_WIDTH-1:0] period_ff;

   logic                    advance;
   logic [CMP_WIDTH-1:0]    now_wide;
   logic [TIME_WIDTH-1:0]   now_t;
   logic [TIME_WIDTH-1:0]   dt;
   logic [CMP_WIDTH-1:0]    dt_wide;
   logic [CMP_WIDTH-1:0]    period_wide;
   logic [CMP_WIDTH-1:0]    period_twice;
   logic [CMP_WIDTH-1:0]    start_plus;
   logic                    due;
   logic                    late;
   logic                    occurred;

   assign advance   = req_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // wrap-safe elapsed time
   assign now_wide     = CMP_WIDTH'(req_ff.now_ms);
   assign now_t        = now_wide[TIME_WIDTH-1:0];
   assign dt           = now_t - start_ff;
   assign dt_wide      = CMP_WIDTH'(dt);
   assign period_wide  = CMP_WIDTH'(period_ff);
   assign period_twice = period_wide << 1;
   assign start_plus   = CMP_WIDTH'(start_ff) + period_wide;
   assign due          = dt_wide >= period_wide;
   assign late         = dt_wide > period_twice;

   // next state
   always_comb begin
      state_in = state_ff;
      start_in = start_ff;
      occurred = 1'b0;
      unique case (req_ff.opcode)
         OP_CHECK: begin
            priority if (state_ff == ST_STOPPED) begin
               occurred = 1'b0;
            end else if (state_ff == ST_ELAPSED) begin
               occurred = 1'b1;
            end else if (due) begin
               occurred = 1'b1;
               unique case (mode_ff)
                  MODE_PERIODIC: start_in = now_t;
                  MODE_HARD: begin
                     if (late) begin
                        start_in = now_t;
                     end else begin
                        start_in = start_plus[TIME_WIDTH-1:0];
                     end
                  end
                  default: state_in = ST_ELAPSED;
               endcase
            end else begin
               occurred = 1'b0;
            end
         end
         OP_START: begin
            if (state_ff != ST_RUNNING) begin
               state_in = ST_RUNNING;
               start_in = now_t;
            end
         end
         OP_STOP: state_in = ST_STOPPED;
         default: ;
      endcase
   end

   // result word
   always_comb begin
      rsp_in.occurred    = occurred;
      rsp_in.timer_state = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STOPPED;
         start_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ONESHOT;
         period_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TIMER_MODE: mode_ff   <= csr_wdata[1:0];
            CSR_PERIOD_MS:  period_ff <= csr_wdata[PERIOD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   a_advance_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("word left input register without a result");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      $past(advance) |-> (rsp_ff.timer_state == state_ff))
      else $error("result state differs from run state");

   a_occurred_not_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.occurred) |-> (rsp_ff.timer_state != ST_STOPPED))
      else $error("event reported on a stopped timer");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> !req_stall)
      else $error("stall with empty input register");

endmodule

FILE: bench/soft_timer_three_mode_tb.sv
// soft_timer_three_mode_tb: self-checking bench for the three-mode software timer,
// directed table then random command streams checked against an in-bench timer model
// depends on stm_pkg and soft_timer_three_mode
module soft_timer_three_mode_tb;
   import stm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 300000;
   localparam int         RANDOM_WORDS = 1420;

   typedef struct {
      bit                 is_csr;
      csr_index_type      csr_sel;
      logic [31:0]        csr_val;
      req_type            word;
      bit                 has_typed;
      rsp_type            typed_rsp;
   } plan_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   soft_timer_three_mode u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // timer model state and registers
   state_type   run_st   = ST_STOPPED;
   logic [31:0] start_t  = '0;
   logic [1:0]  mode_r   = MODE_ONESHOT;
   logic [31:0] period_r = '0;

   rsp_type      pending_rsp[$];
   plan_row_type plan[$];
   int           fail_count = 0;
   int           cycle_count = 0;
   int           burst_left = 1;
   bit           long_hold_due = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic rsp_type step_timer(input req_type w);
      rsp_type     r;
      logic [31:0] dt;
      logic        occ;
      occ = 1'b0;
      case (w.opcode)
         OP_CHECK: begin
            if (run_st == ST_ELAPSED) begin
               occ = 1'b1;
            end else if (run_st == ST_RUNNING) begin
               dt = w.now_ms - start_t;
               if (dt >= period_r) begin
                  occ = 1'b1;
                  if (mode_r == MODE_PERIODIC) begin
                     start_t = w.now_ms;
                  end else if (mode_r == MODE_HARD) begin
                     if (dt > period_r && (dt - period_r) > period_r) start_t = w.now_ms;
                     else start_t = start_t + period_r;
                  end else begin
                     run_st = ST_ELAPSED;
                  end
               end
            end
         end
         OP_START: begin
            if (run_st != ST_RUNNING) begin
               run_st  = ST_RUNNING;
               start_t = w.now_ms;
            end
         end
         OP_STOP: run_st = ST_STOPPED;
         default: ;
      endcase
      r.occurred    = occ;
      r.timer_state = run_st;
      return r;
   endfunction

   task automatic note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   always @(posedge clock) begin : watch_rsp
      rsp_type exp_w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            note_fail($sformatf("unexpected result word occurred=%0d state=%0d",
                                rsp_data.occurred, rsp_data.timer_state));
         end else begin
            exp_w = pending_rsp.pop_front();
            if (rsp_data.occurred !== exp_w.occurred ||
                rsp_data.timer_state !== exp_w.timer_state)
               note_fail($sformatf("mismatch: expected occurred=%0d state=%0d, got %0d/%0d",
                                   exp_w.occurred, exp_w.timer_state,
                                   rsp_data.occurred, rsp_data.timer_state));
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   initial begin : drive_rsp_stall
      int seg_left;
      int style;
      int hold_left;
      bit hold_done;
      seg_left  = 0;
      style     = 0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (long_hold_due && !hold_done) begin
            hold_left = 80;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               style    = $urandom_range(0, 3);
               seg_left = $urandom_range(10, 150);
            end
            seg_left--;
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 9) < 7);
               default: rsp_stall <= ((seg_left % 5) == 0);
            endcase
         end
      end
   end

   task automatic send_word(input req_type w, input rsp_type typed, input bit use_typed);
      rsp_type pred;
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = step_timer(w);
      pending_rsp.push_back(use_typed ? typed : pred);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TIMER_MODE) mode_r = val[1:0];
      else period_r = val;
   endtask

   function automatic plan_row_type blank_row();
      plan_row_type p;
      p.is_csr    = 1'b0;
      p.csr_sel   = CSR_TIMER_MODE;
      p.csr_val   = '0;
      p.word      = '0;
      p.has_typed = 1'b0;
      p.typed_rsp = '0;
      return p;
   endfunction

   function automatic void add_word(input logic [1:0] op, input logic [31:0] now_v);
      plan_row_type p;
      p = blank_row();
      p.word.opcode = op;
      p.word.now_ms = now_v;
      plan.push_back(p);
   endfunction

   function automatic void add_typed(input logic [1:0] op, input logic [31:0] now_v,
                                     input logic occ, input state_type st);
      plan_row_type p;
      p = blank_row();
      p.word.opcode = op;
      p.word.now_ms = now_v;
      p.has_typed = 1'b1;
      p.typed_rsp.occurred = occ;
      p.typed_rsp.timer_state = st;
      plan.push_back(p);
   endfunction

   function automatic void add_csr(input csr_index_type idx, input logic [31:0] val);
      plan_row_type p;
      p = blank_row();
      p.is_csr  = 1'b1;
      p.csr_sel = idx;
      p.csr_val = val;
      plan.push_back(p);
   endfunction

   initial begin : run_stimulus
      req_type     w;
      logic [31:0] period_v;
      logic [31:0] delta;
      logic [31:0] now_cur;
      logic [1:0]  mode_v;
      int          random_sent;
      int          phase;
      int          n;
      int          pick;

      // reset values: one-shot, zero period, stopped
      add_typed(OP_CHECK, 32'h0, 1'b0, ST_STOPPED);
      add_typed(OP_CHECK, 32'hFFFF_FFFF, 1'b0, ST_STOPPED);
      add_typed(OP_UNUSED, 32'h5A5A_5A5A, 1'b0, ST_STOPPED);
      add_typed(OP_START, 32'hFFFF_FFFF, 1'b0, ST_RUNNING);
      add_typed(OP_CHECK, 32'h0, 1'b1, ST_ELAPSED);
      add_typed(OP_START, 32'd5, 1'b0, ST_RUNNING);
      add_typed(OP_START, 32'd100, 1'b0, ST_RUNNING);
      add_typed(OP_STOP, 32'd200, 1'b0, ST_STOPPED);
      // hard periodic, largest period
      add_csr(CSR_TIMER_MODE, {30'd0, MODE_HARD});
      add_csr(CSR_PERIOD_MS, 32'hFFFF_FFFF);
      add_typed(OP_START, 32'h0, 1'b0, ST_RUNNING);
      add_word(OP_CHECK, 32'hFFFF_FFFE);
      add_word(OP_CHECK, 32'hFFFF_FFFF);
      add_word(OP_CHECK, 32'h0);
      // hard periodic catch-up and restart across the wrap
      add_csr(CSR_PERIOD_MS, 32'd10);
      add_word(OP_STOP, 32'd0);
      add_word(OP_START, 32'hFFFF_FFF8);
      add_word(OP_CHECK, 32'd2);
      add_word(OP_CHECK, 32'd23);
      add_word(OP_CHECK, 32'd43);
      add_csr(CSR_TIMER_MODE, {30'd0, MODE_PERIODIC});
      add_csr(CSR_PERIOD_MS, 32'd1);
      add_word(OP_CHECK, 32'd50);
      add_word(OP_CHECK, 32'd50);
      add_word(OP_CHECK, 32'd51);
      // unused mode acts as one-shot
      add_csr(CSR_TIMER_MODE, {30'd0, MODE_UNUSED});
      add_csr(CSR_PERIOD_MS, 32'h8000_0001);
      add_word(OP_STOP, 32'd0);
      add_word(OP_START, 32'd0);
      add_word(OP_CHECK, 32'h8000_0000);
      add_word(OP_CHECK, 32'h8000_0001);
      add_word(OP_CHECK, 32'd0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_reg(plan[i].csr_sel, plan[i].csr_val);
         else send_word(plan[i].word, plan[i].typed_rsp, plan[i].has_typed);
      end

      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_WORDS) begin
         phase++;
         mode_v = (phase <= 4) ? 2'(phase - 1) : 2'($urandom_range(0, 3));
         case ($urandom_range(0, 7))
            0: period_v = 32'd0;
            1: period_v = 32'hFFFF_FFFF;
            2: period_v = 32'd1;
            3: period_v = $urandom_range(2, 20);
            4: period_v = $urandom_range(21, 5000);
            5: period_v = $urandom;
            6: period_v = $urandom_range(32'h7FFF_FFFE, 32'h8000_0002);
            default: period_v = $urandom_range(100, 1000000);
         endcase
         write_reg(CSR_TIMER_MODE, {30'd0, mode_v});
         write_reg(CSR_PERIOD_MS, period_v);
         if (phase == 2) long_hold_due = 1;
         now_cur = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 50)
                                                : $urandom;
         n = $urandom_range(30, 66);
         for (int k = 0; k < n && random_sent < RANDOM_WORDS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) w.opcode = OP_CHECK;
            else if (pick < 84) w.opcode = OP_START;
            else if (pick < 94) w.opcode = OP_STOP;
            else w.opcode = OP_UNUSED;
            if (k == 0 && $urandom_range(0, 4) != 0) w.opcode = OP_START;
            case ($urandom_range(0, 9))
               0: delta = 32'd0;
               1: delta = 32'd1;
               2, 3, 4: delta = $urandom_range(0, period_v >> 1);
               5, 6: delta = period_v - 32'd1 + $urandom_range(0, 2);
               7: delta = (period_v << 1) - 32'd1 + $urandom_range(0, 2);
               8: delta = $urandom;
               default: delta = period_v;
            endcase
            now_cur = now_cur + delta;
            w.now_ms = ($urandom_range(0, 19) == 0) ? 32'($urandom) : now_cur;
            send_word(w, '0, 1'b0);
            random_sent++;
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
